// File: src/wsp_pkg.sv
// Shared types and constants for the wheel speed PID core
`timescale 1ns / 1ps
package wsp_pkg;
    localparam int unsigned IdxGainP  = 0;
    localparam int unsigned IdxGainI  = 1;
    localparam int unsigned IdxGainD  = 2;
    localparam int unsigned IdxScale  = 3;
    localparam logic signed [31:0] S32Max = 32'sh7fffffff;
    localparam logic signed [31:0] S32Min = -32'sh7fffffff - 32'sd1;
    localparam logic signed [17:0] QOne   = 18'sd65536;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_STEP,
        OP_SPEED_MUL,
        OP_SPEED_DIV,
        OP_ERR,
        OP_P,
        OP_ERRDT,
        OP_IINC,
        OP_ISUM,
        OP_DDIFF,
        OP_DDIV,
        OP_D,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load;
        logic div_start;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'(S32Max)) r = S32Max;
        else if (v < 66'(S32Min)) r = S32Min;
        else r = v[31:0];
        return r;
    endfunction
endpackage

// File: src/wsp_div.sv
// Restoring divider for signed 42-bit dividend by 16-bit divisor, truncating
`timescale 1ns / 1ps
module wsp_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [41:0] dividend,
    input  logic [15:0]        divisor,
    output logic               busy,
    output logic signed [42:0] quotient
);
    logic [41:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] dv_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic [16:0] trial;
    logic [41:0] mag;

    assign mag = dividend[41] ? 42'(-dividend) : dividend;
    assign trial = {r_reg[15:0], q_reg[41]};
    always_comb
    begin
        q_next = {q_reg[40:0], 1'b0};
        r_next = trial;
        if (trial >= {1'b0, dv_reg})
        begin
            r_next = trial - {1'b0, dv_reg};
            q_next[0] = 1'b1;
        end
        cnt_next = cnt_reg - 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd42;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= mag;
            r_reg   <= '0;
            dv_reg  <= divisor;
            neg_reg <= dividend[41];
        end
        else if (cnt_reg != 6'd0)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign busy = (cnt_reg != 6'd0);
    assign quotient = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
endmodule

// File: src/wsp_datapath.sv
// Datapath: state, shared multiplier and divider for the PID update
`timescale 1ns / 1ps
module wsp_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  wsp_pkg::cmd_t      cmd,
    output wsp_pkg::status_t   status,
    input  logic signed [31:0] pulse_count,
    input  logic [15:0]        elapsed_ms,
    input  logic signed [31:0] speed_target,
    output logic signed [17:0] drive,
    output logic signed [31:0] measured_speed,
    output logic signed [31:0] distance_step
);
    logic [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [15:0] scale_reg;
    logic signed [31:0] last_pos_reg, last_err_reg, isum_reg;
    logic signed [31:0] pos_reg, tgt_reg;
    logic [15:0] dt_reg;
    logic signed [31:0] step_reg, speed_reg, err_reg, p_reg, tmp_reg, d_reg;
    logic signed [41:0] acc_reg;
    logic signed [17:0] drive_reg;
    logic signed [42:0] quo;
    logic        div_busy;
    logic [31:0] mag;
    logic [31:0] gsel;
    logic [63:0] prod;
    logic signed [65:0] mq;
    logic signed [33:0] diff;
    logic signed [33:0] sum3;

    wsp_div u_div
    (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(acc_reg),
        .divisor(dt_reg), .busy(div_busy), .quotient(quo)
    );

    assign status.div_busy = div_busy;

    always_comb
    begin
        unique case (cmd.op)
            wsp_pkg::OP_P:    gsel = gain_p_reg;
            wsp_pkg::OP_IINC: gsel = gain_i_reg;
            default:          gsel = gain_d_reg;
        endcase
        mag  = tmp_reg[31] ? 32'(-tmp_reg) : tmp_reg;
        prod = mag * gsel;
        mq   = tmp_reg[31] ? -$signed({2'b0, 16'b0, prod[63:16]})
                           : $signed({2'b0, 16'b0, prod[63:16]});
        diff = 34'(pos_reg) - 34'(last_pos_reg);
        sum3 = 34'(p_reg) + 34'(isum_reg) + 34'(d_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            scale_reg    <= 16'd1;
            last_pos_reg <= '0;
            last_err_reg <= '0;
            isum_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    2'(wsp_pkg::IdxGainP): gain_p_reg <= cfg_data;
                    2'(wsp_pkg::IdxGainI): gain_i_reg <= cfg_data;
                    2'(wsp_pkg::IdxGainD): gain_d_reg <= cfg_data;
                    default:               scale_reg  <= cfg_data[15:0];
                endcase
            end
            if (cmd.op == wsp_pkg::OP_STEP)
                last_pos_reg <= pos_reg;
            if (cmd.op == wsp_pkg::OP_ISUM)
                isum_reg <= wsp_pkg::sat32(66'(isum_reg) + 66'(tmp_reg));
            if (cmd.op == wsp_pkg::OP_D)
                last_err_reg <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg <= pulse_count;
            tgt_reg <= speed_target;
            dt_reg  <= (elapsed_ms == 16'd0) ? 16'd1 : elapsed_ms;
        end
        unique case (cmd.op)
            wsp_pkg::OP_STEP:
                step_reg <= wsp_pkg::sat32(66'(diff) * 66'($signed({1'b0, scale_reg})));
            wsp_pkg::OP_SPEED_MUL:
                acc_reg <= 42'(step_reg * 42'sd1000);
            wsp_pkg::OP_SPEED_DIV:
                speed_reg <= wsp_pkg::sat32(66'(quo));
            wsp_pkg::OP_ERR:
            begin
                err_reg <= wsp_pkg::sat32(66'(tgt_reg) - 66'(speed_reg));
                tmp_reg <= wsp_pkg::sat32(66'(tgt_reg) - 66'(speed_reg));
            end
            wsp_pkg::OP_P:
                p_reg <= wsp_pkg::sat32(mq);
            wsp_pkg::OP_ERRDT:
                tmp_reg <= wsp_pkg::sat32(66'(err_reg) * 66'($signed({1'b0, dt_reg})));
            wsp_pkg::OP_IINC:
                tmp_reg <= wsp_pkg::sat32(mq);
            wsp_pkg::OP_DDIFF:
                acc_reg <= 42'(err_reg) - 42'(last_err_reg);
            wsp_pkg::OP_DDIV:
                tmp_reg <= wsp_pkg::sat32(66'(quo));
            wsp_pkg::OP_D:
                d_reg <= wsp_pkg::sat32(mq);
            wsp_pkg::OP_OUT:
                if (sum3 > 34'(wsp_pkg::QOne)) drive_reg <= wsp_pkg::QOne;
                else if (sum3 < -34'(wsp_pkg::QOne)) drive_reg <= -wsp_pkg::QOne;
                else drive_reg <= sum3[17:0];
            default: ;
        endcase
    end

    assign drive          = drive_reg;
    assign measured_speed = speed_reg;
    assign distance_step  = step_reg;
endmodule

// File: src/wsp_ctrl.sv
// Controller sequencing one PID update and the stream handshake
`timescale 1ns / 1ps
module wsp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  wsp_pkg::status_t status,
    output wsp_pkg::cmd_t    cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_STEP, S_SMUL, S_SDIV_GO, S_SDIV, S_ERR, S_P, S_ERRDT,
        S_IINC, S_ISUM, S_DDIFF, S_DDIV_GO, S_DDIV, S_D, S_OUT, S_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   wait_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_HOLD);

    always_comb
    begin
        cmd = '{op: wsp_pkg::OP_IDLE, load: 1'b0, div_start: 1'b0};
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) begin cmd.load = 1'b1; state_next = S_STEP; end
            S_STEP:    begin cmd.op = wsp_pkg::OP_STEP; state_next = S_SMUL; end
            S_SMUL:    begin cmd.op = wsp_pkg::OP_SPEED_MUL; state_next = S_SDIV_GO; end
            S_SDIV_GO: begin cmd.div_start = 1'b1; state_next = S_SDIV; end
            S_SDIV:    if (!status.div_busy && !wait_reg)
                       begin cmd.op = wsp_pkg::OP_SPEED_DIV; state_next = S_ERR; end
            S_ERR:     begin cmd.op = wsp_pkg::OP_ERR; state_next = S_P; end
            S_P:       begin cmd.op = wsp_pkg::OP_P; state_next = S_ERRDT; end
            S_ERRDT:   begin cmd.op = wsp_pkg::OP_ERRDT; state_next = S_IINC; end
            S_IINC:    begin cmd.op = wsp_pkg::OP_IINC; state_next = S_ISUM; end
            S_ISUM:    begin cmd.op = wsp_pkg::OP_ISUM; state_next = S_DDIFF; end
            S_DDIFF:   begin cmd.op = wsp_pkg::OP_DDIFF; state_next = S_DDIV_GO; end
            S_DDIV_GO: begin cmd.div_start = 1'b1; state_next = S_DDIV; end
            S_DDIV:    if (!status.div_busy && !wait_reg)
                       begin cmd.op = wsp_pkg::OP_DDIV; state_next = S_D; end
            S_D:       begin cmd.op = wsp_pkg::OP_D; state_next = S_OUT; end
            S_OUT:     begin cmd.op = wsp_pkg::OP_OUT; state_next = S_HOLD; end
            S_HOLD:    if (out_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= cmd.div_start;
        end
    end

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready and valid together");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> status.div_busy) else $error("divider did not start");
endmodule

// File: src/wheel_speed_pid_core.sv
// Top level of the wheel speed PID core
`timescale 1ns / 1ps
// One request is processed at a time: the time from acceptance to a valid result is set
// mostly by two passes of the 42-step shared divider (speed and derivative), and a new
// request can be taken in the cycle after the result has been taken.
module wheel_speed_pid_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // pulse_count, elapsed_ms, speed_target
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // drive, measured_speed, distance_step, zero pad
);
    wsp_pkg::cmd_t    cmd;
    wsp_pkg::status_t status;
    logic signed [17:0] drive;
    logic signed [31:0] speed, step;

    wsp_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .status(status), .cmd(cmd)
    );

    wsp_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd), .status(status),
        .pulse_count(s_tdata[31:0]), .elapsed_ms(s_tdata[47:32]),
        .speed_target(s_tdata[79:48]), .drive(drive),
        .measured_speed(speed), .distance_step(step)
    );

    assign m_tdata = {6'b0, step, speed, drive};
endmodule

// File: bench/testbench.sv
// Self-checking regression bench for the wheel speed PID core
`timescale 1ns / 1ps
module testbench;
    typedef struct packed {
        logic signed [17:0] drive;
        logic signed [31:0] speed;
        logic signed [31:0] dist_step;
    } wheel_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    wheel_result_t expected_q[$];
    int  mismatches = 0;
    int  holdoff_cycles = 0;
    bit  steady = 1'b0;
    logic [31:0] kp, ki, kd;
    logic [15:0] scale;
    longint prev_pos, prev_err, isum;
    logic signed [31:0] pos_track;

    wheel_speed_pid_core uut (.*);

    always #10 clk = ~clk;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint gain_mul(longint a, logic [31:0] g);
        longint unsigned mag, prod;
        mag = (a < 0) ? longint'(-a) : a;
        prod = (mag * {32'd0, g}) >> 16;
        return (a < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic wheel_result_t predict_update(logic signed [31:0] pos, logic [15:0] ms,
                                                     logic signed [31:0] tgt);
        wheel_result_t r;
        longint dt, step, spd, err, p, d, sum;
        dt = (ms == 0) ? 1 : longint'(ms);
        step = clamp32((longint'(pos) - prev_pos) * longint'(scale));
        prev_pos = pos;
        spd = clamp32((step * 1000) / dt);
        err = clamp32(longint'(tgt) - spd);
        p = clamp32(gain_mul(err, kp));
        isum = clamp32(isum + clamp32(gain_mul(clamp32(err * dt), ki)));
        d = clamp32(gain_mul(clamp32((err - prev_err) / dt), kd));
        prev_err = err;
        sum = p + isum + d;
        if (sum > 65536) sum = 65536;
        if (sum < -65536) sum = -65536;
        r.drive = sum[17:0];
        r.speed = spd[31:0];
        r.dist_step = step[31:0];
        return r;
    endfunction

    always @(negedge clk)
    begin
        if (holdoff_cycles > 0)
        begin
            holdoff_cycles <= holdoff_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= steady || ($urandom_range(0, 99) >= 6);
    end

    always @(posedge clk)
    begin
        wheel_result_t got, want;
        if (m_tvalid && m_tready)
        begin
            got.drive = m_tdata[17:0];
            got.speed = m_tdata[49:18];
            got.dist_step = m_tdata[81:50];
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: drive %0d/%0d speed %0d/%0d dist %0d/%0d (exp/got)",
                                 want.drive, got.drive, want.speed, got.speed,
                                 want.dist_step, got.dist_step);
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            2'(wsp_pkg::IdxGainP): kp = val;
            2'(wsp_pkg::IdxGainI): ki = val;
            2'(wsp_pkg::IdxGainD): kd = val;
            default: scale = val[15:0];
        endcase
        @(negedge clk);
    endtask

    task automatic set_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d, logic [15:0] sc);
        write_reg(2'(wsp_pkg::IdxGainP), p);
        write_reg(2'(wsp_pkg::IdxGainI), i);
        write_reg(2'(wsp_pkg::IdxGainD), d);
        write_reg(2'(wsp_pkg::IdxScale), {16'd0, sc});
        cfg_we <= 1'b0;
    endtask

    task automatic send_update(logic signed [31:0] pos, logic [15:0] ms, logic signed [31:0] tgt);
        if (!steady && $urandom_range(0, 99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < 30)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {tgt, ms, pos};
        pos_track = pos;
        do
            @(posedge clk);
        while (!s_tready);
        expected_q.push_back(predict_update(pos, ms, tgt));
        @(negedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_target();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
    endfunction

    task automatic test_directed;
        set_gains(32'h0001_0000, 32'h0000_0100, 32'h0000_4000, 16'h0100);
        send_update(32'sd100, 16'd0, 32'sd65536);
        send_update(32'sd150, 16'd10, 32'sd65536);
        send_update(32'sh7fffffff, 16'd1, 32'sh7fffffff);
        send_update(-32'sh80000000, 16'd1, -32'sh80000000);
        send_update(32'sh7fffffff, 16'd65535, 32'sd0);
        send_update(32'sh7fffffff, 16'd65535, -32'sd1);
        send_update(-32'sd5, 16'd0, -32'sh80000000);
        send_update(32'sd0, 16'd2, 32'sd0);
        drain();
        set_gains(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
        send_update(32'sh7fffffff, 16'd0, 32'sd0);
        send_update(-32'sh80000000, 16'd3, 32'sh7fffffff);
        send_update(-32'sh80000000, 16'd65535, -32'sd65536);
        send_update(32'sd1, 16'd1, 32'sd1);
        drain();
        set_gains(32'd0, 32'd0, 32'd0, 16'd0);
        send_update(32'sd12345, 16'd7, 32'sd65536);
        send_update(-32'sd99, 16'd0, -32'sd65537);
        drain();
    endtask

    task automatic random_phase(int count);
        logic signed [31:0] pos;
        int n;
        set_gains($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0000_1000),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0001_0000),
                  $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16'h0400)));
        for (n = 0; n < count; n++)
        begin
            pos = pos_track + $signed($urandom_range(0, 400)) - 200;
            if ($urandom_range(0, 9) == 0)
                pos = $urandom;
            send_update(pos, $urandom_range(0, 19) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20)),
                        rand_target());
        end
        drain();
    endtask

    task automatic test_random;
        int ph;
        for (ph = 0; ph < 16; ph++)
        begin
            steady = (ph == 5);
            random_phase(100);
        end
        steady = 1'b0;
    endtask

    task automatic test_backpressure;
        int n;
        holdoff_cycles = 600;
        for (n = 0; n < 20; n++)
            send_update(pos_track + 32'sd37, 16'd5, rand_target());
        drain();
    endtask

    initial
    begin
        kp = '0; ki = '0; kd = '0; scale = 16'd1;
        prev_pos = 0; prev_err = 0; isum = 0; pos_track = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("wheel_speed_pid_core regression: pass");
        else
            $display("wheel_speed_pid_core regression: fail");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("wheel_speed_pid_core regression: fail");
        $finish;
    end
endmodule

// File: sim.f
src/wsp_pkg.sv
src/wsp_div.sv
src/wsp_datapath.sv
src/wsp_ctrl.sv
src/wheel_speed_pid_core.sv
bench/testbench.sv
